// ----- src/ttoi_pkg.sv -----
// Shared types, character codes and decode helpers for the text-to-integer parser.
// No dependencies; imported by ttoi_accum and text_to_integer_parser.
`timescale 1ns / 1ps

package ttoi_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  // Radix values
  localparam logic [5:0] BASE_AUTO  = 6'd0;
  localparam logic [5:0] BASE_UNARY = 6'd1;
  localparam logic [5:0] BASE_MIN   = 6'd2;
  localparam logic [5:0] BASE_OCT   = 6'd8;
  localparam logic [5:0] BASE_DEC   = 6'd10;
  localparam logic [5:0] BASE_HEX   = 6'd16;
  localparam logic [5:0] BASE_MAX   = 6'd36;

  localparam logic [6:0] DIGIT_NONE = 7'd99;
  localparam logic [6:0] DIGIT_HEX_LIMIT = 7'd16;

  localparam logic [15:0] MAX_STRING_LEN = 16'hFFFF;

  // Register map (word index)
  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_SIGNED = 2'd1;
  localparam logic [1:0] REG_WIDE   = 2'd2;

  localparam logic [63:0] MAX_S64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX_U64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX_S32 = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] MAX_U32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] MIN_S64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MIN_S32 = 64'hFFFF_FFFF_8000_0000;

  typedef enum logic [5:0] {
    PH_SPACE  = 6'b000001,
    PH_START  = 6'b000010,
    PH_ZERO   = 6'b000100,
    PH_PREFIX = 6'b001000,
    PH_DIGITS = 6'b010000,
    PH_DRAIN  = 6'b100000
  } phase_t;

  // Request to / response from the digit accumulate unit
  typedef struct packed {
    logic [63:0] acc;
    logic [5:0]  base;
    logic [5:0]  digit;
    logic [63:0] limit;
    logic        overflowed;
  } acc_req_t;

  typedef struct packed {
    logic [63:0] acc;
    logic        overflowed;
  } acc_rsp_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

  function automatic logic [6:0] digit_of(input logic [7:0] c);
    logic [6:0] d;
    d = DIGIT_NONE;
    if (c inside {[CH_ZERO:CH_NINE]}) d = 7'(c - CH_ZERO);
    else if (c inside {[CH_LO_A:CH_LO_Z]}) d = 7'(c - CH_LO_A) + 7'd10;
    else if (c inside {[CH_UP_A:CH_UP_Z]}) d = 7'(c - CH_UP_A) + 7'd10;
    return d;
  endfunction

  function automatic logic [63:0] type_max(input logic sgn, input logic wide);
    logic [63:0] m;
    if (wide) m = sgn ? MAX_S64 : MAX_U64;
    else      m = sgn ? MAX_S32 : MAX_U32;
    return m;
  endfunction

endpackage

// ----- src/text_to_integer_parser.sv -----
// Streaming string-to-integer parser, top level.
// Depends on ttoi_pkg and ttoi_accum.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid / in_stall, payload ch, last): one character per
//   item; last marks the final character of a string. A 0 byte ends the
//   number. Leading whitespace, an optional sign and an 0x / 0 prefix are
//   handled; digits accumulate in the configured base with saturation.
//   Output channel (out_valid / out_stall, payload value, out_of_range,
//   end_offset, converted): exactly one item per string, issued at the
//   character that ends the number. Remaining characters of that string are
//   swallowed up to and including the one marked last.
//   Config (APB, pready always high): 0x0 number_base, 0x4 is_signed,
//   0x8 wide_result. Write only while no string is in flight.
// Timing
//   One character per cycle sustained while no result waits under out_stall.
//   An ending character accepted into the input register is parsed there, and
//   the 64x6 multiply, add and limit compare land in the result register.
// Reset / stall
//   rst (synchronous) clears the parse state to "skipping whitespace", empties
//   both registers and sets base 0, signed, 64-bit. While a result waits under
//   out_stall, in_stall is high whenever the input register holds a character.

module text_to_integer_parser
  import ttoi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // character stream
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ch,
  input  logic        last,
  // result stream
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] value,
  output logic        out_of_range,
  output logic [15:0] end_offset,
  output logic        converted,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------- config
  logic [5:0] number_base;
  logic       is_signed;
  logic       wide_result;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_AUTO;
      is_signed   <= 1'b1;
      wide_result <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_BASE:   number_base <= pwdata[5:0];
        REG_SIGNED: is_signed   <= pwdata[0];
        REG_WIDE:   wide_result <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE:   prdata = {26'd0, number_base};
      REG_SIGNED: prdata = {31'd0, is_signed};
      REG_WIDE:   prdata = {31'd0, wide_result};
      default:    prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------- input register
  logic       s_valid;
  logic [7:0] s_ch;
  logic       s_last;
  logic       adv;     // result register can take a new item this cycle
  logic       fire;    // held character is processed this cycle

  assign adv      = !out_valid || !out_stall;
  assign in_stall = s_valid && !adv;
  assign fire     = s_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_ch   <= ch;
      s_last <= last;
    end
  end

  // ------------------------------------------------------------ parse state
  phase_t      phase;
  logic        negative;
  logic [5:0]  active_base;
  logic [63:0] accumulator;
  logic        overflowed;
  logic [15:0] position;
  logic [15:0] good_end;
  logic        digit_seen;

  // ------------------------------------------------------------ char decode
  logic [6:0] d;
  logic       done;
  logic       do_acc;
  logic [5:0] acc_digit;
  logic [5:0] base_next;
  logic       negative_next;
  phase_t     phase_next;
  logic       start_path;
  logic       take_path;

  assign d = digit_of(s_ch);

  always_comb begin
    done          = 1'b0;
    do_acc        = 1'b0;
    acc_digit     = 6'd0;
    base_next     = active_base;
    negative_next = negative;
    phase_next    = phase;
    start_path    = 1'b0;
    take_path     = 1'b0;

    if (s_ch == CH_NUL) begin
      done = 1'b1;
    end else begin
      case (phase)
        PH_SPACE: begin
          if (!is_space(s_ch)) begin
            base_next = number_base;
            if (base_next == BASE_UNARY || base_next > BASE_MAX) begin
              done = 1'b1;
            end else if (s_ch == CH_MINUS) begin
              negative_next = 1'b1;
              phase_next    = PH_START;
            end else if (s_ch == CH_PLUS) begin
              phase_next = PH_START;
            end else begin
              start_path = 1'b1;
            end
          end
        end
        PH_START: start_path = 1'b1;
        PH_ZERO: begin
          if (s_ch == CH_LO_X || s_ch == CH_UP_X) begin
            phase_next = PH_PREFIX;
          end else begin
            if (active_base == BASE_AUTO) base_next = BASE_OCT;
            take_path = 1'b1;
          end
        end
        PH_PREFIX: begin
          // "0x" not followed by a hex digit: only the zero counts
          if (d >= DIGIT_HEX_LIMIT) begin
            done = 1'b1;
          end else begin
            base_next = BASE_HEX;
            take_path = 1'b1;
          end
        end
        PH_DIGITS: take_path = 1'b1;
        default:   done = 1'b1;
      endcase
    end

    // first character of the number proper
    if (start_path) begin
      if (s_ch == CH_ZERO && (base_next == BASE_AUTO || base_next == BASE_HEX)) begin
        do_acc     = 1'b1;
        phase_next = PH_ZERO;
      end else begin
        if (base_next == BASE_AUTO) base_next = BASE_DEC;
        take_path = 1'b1;
      end
    end

    if (take_path) begin
      if (d >= {1'b0, base_next}) begin
        done = 1'b1;
      end else begin
        do_acc     = 1'b1;
        acc_digit  = d[5:0];
        phase_next = PH_DIGITS;
      end
    end
  end

  // ------------------------------------------------------------- accumulate
  acc_req_t acc_req;
  acc_rsp_t acc_rsp;

  // signed negative magnitude may reach max + 1 so that the minimum fits
  assign acc_req.acc        = accumulator;
  assign acc_req.base       = base_next;
  assign acc_req.digit      = acc_digit;
  assign acc_req.limit      = type_max(is_signed, wide_result)
                              + 64'(is_signed && negative_next);
  assign acc_req.overflowed = overflowed;

  ttoi_accum u_accum (
    .req (acc_req),
    .rsp (acc_rsp)
  );

  // ------------------------------------------------------------ next values
  logic [16:0] pos_p1;
  logic [15:0] good_end_upd;
  logic [15:0] position_upd;
  logic [63:0] acc_upd;
  logic        ovf_upd;
  logic [15:0] good_end_next;
  logic        seen_upd;
  logic        end_now;
  logic        emit_now;
  logic        drain;

  assign drain        = (phase == PH_DRAIN);
  assign pos_p1       = {1'b0, position} + 17'd1;
  assign good_end_upd = (pos_p1 > {1'b0, MAX_STRING_LEN}) ? MAX_STRING_LEN : pos_p1[15:0];
  assign position_upd = (position < MAX_STRING_LEN) ? pos_p1[15:0] : position;
  assign acc_upd      = do_acc ? acc_rsp.acc : accumulator;
  assign ovf_upd      = do_acc ? acc_rsp.overflowed : overflowed;
  assign good_end_next = do_acc ? good_end_upd : good_end;
  assign seen_upd     = do_acc || digit_seen;
  assign end_now      = done || s_last;
  assign emit_now     = fire && !drain && end_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SPACE;
      negative    <= 1'b0;
      active_base <= BASE_AUTO;
      accumulator <= 64'd0;
      overflowed  <= 1'b0;
      position    <= 16'd0;
      good_end    <= 16'd0;
      digit_seen  <= 1'b0;
    end else if (fire) begin
      if (s_last) begin
        // string over: start fresh for the next one
        phase       <= PH_SPACE;
        negative    <= 1'b0;
        active_base <= BASE_AUTO;
        accumulator <= 64'd0;
        overflowed  <= 1'b0;
        position    <= 16'd0;
        good_end    <= 16'd0;
        digit_seen  <= 1'b0;
      end else if (!drain) begin
        phase       <= done ? PH_DRAIN : phase_next;
        negative    <= negative_next;
        active_base <= base_next;
        accumulator <= acc_upd;
        overflowed  <= ovf_upd;
        position    <= position_upd;
        good_end    <= good_end_next;
        digit_seen  <= seen_upd;
      end
    end
  end

  // --------------------------------------------------------- result register
  // Holds raw parse results; final value formatting is done on the way out.
  logic [63:0] r_acc;
  logic        r_ovf;
  logic        r_neg;
  logic        r_seen;
  logic [15:0] r_end;
  logic        r_signed;
  logic        r_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= emit_now;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit_now) begin
      r_acc    <= acc_upd;
      r_ovf    <= ovf_upd;
      r_neg    <= negative_next;
      r_seen   <= seen_upd;
      r_end    <= good_end_next;
      r_signed <= is_signed;
      r_wide   <= wide_result;
    end
  end

  always_comb begin
    value        = 64'd0;
    out_of_range = 1'b0;
    end_offset   = 16'd0;
    converted    = r_seen;
    if (r_seen) begin
      end_offset = r_end;
      if (r_ovf) begin
        out_of_range = 1'b1;
        if (r_signed && r_neg) value = r_wide ? MIN_S64 : MIN_S32;
        else                   value = type_max(r_signed, r_wide);
      end else begin
        value = r_neg ? (64'd0 - r_acc) : r_acc;
        if (!r_signed && !r_wide) value = value & MAX_U32;
      end
    end
  end

endmodule

// ----- src/ttoi_accum.sv -----
// Digit accumulate unit: acc * base + digit with saturation at a limit.
// Depends on ttoi_pkg (acc_req_t, acc_rsp_t, BASE_MIN).
`timescale 1ns / 1ps

module ttoi_accum
  import ttoi_pkg::*;
(
  input  acc_req_t req,
  output acc_rsp_t rsp
);

  logic [5:0]  b;
  logic [69:0] prod;
  logic [70:0] sum;

  // base below 2 only occurs for a leading zero digit; scale by 2 then
  assign b    = (req.base < BASE_MIN) ? BASE_MIN : req.base;
  assign prod = 70'(req.acc) * 70'(b);
  assign sum  = 71'(prod) + 71'(req.digit);

  // acc > (limit - d) / b  is exactly  acc * b + d > limit
  always_comb begin
    if (req.overflowed) begin
      rsp.acc        = req.acc;
      rsp.overflowed = 1'b1;
    end else if (sum > 71'(req.limit)) begin
      rsp.acc        = req.limit;
      rsp.overflowed = 1'b1;
    end else begin
      rsp.acc        = sum[63:0];
      rsp.overflowed = 1'b0;
    end
  end

endmodule
